// ===== src/iat_pkg.sv =====
package iat_pkg;

  // Command codes carried in the low bits of an input item
  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Stream widths, padded to whole bytes
  localparam int IN_W  = 88;
  localparam int OUT_W = 72;

  // Output item layout
  localparam int OUT_USED = 65;

endpackage

// ===== src/iat_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module iat_div #(
  parameter int NW = 54,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  import iat_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [VW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [VW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [VW:0]   shift_rem;
  logic [VW:0]   trial;
  logic          take;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    shift_rem = {rem_r, quo_r[NW-1]};
    trial     = shift_rem - {1'b0, den_r};
    take      = (shift_rem >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        rem_r  <= '0;
        quo_r  <= dividend;
        den_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= take ? trial[VW-1:0] : shift_rem[VW-1:0];
        quo_r <= {quo_r[NW-2:0], take};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/interpolating_angle_table_top.sv =====
// Channel | Dir | Bits | Contents
// in_     | in  | 88   | command[1:0] angle[17:2] lift[49:18] drag[81:50]
// out_    | out | 72   | found[0] lift_out[32:1] drag_out[64:33], zero pad above
// After reset the table is wiped one bin a cycle; no item is taken meanwhile.
// A store writes its bin as it is accepted; a clear runs the wipe again.
// A query scans the bin memory one entry a cycle,
// and its result is loaded into the output register once that register is free.
// Interpolation runs a lift pass and then a drag pass through the shared serial divider.
// A finished result waits in the output register; in_tready stays high meanwhile
// until a query or a clear is accepted.
module interpolating_angle_table_top #(
  parameter int ANGLE_BINS = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [iat_pkg::IN_W-1:0]  in_tdata,  // command, angle, lift, drag
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [iat_pkg::OUT_W-1:0] out_tdata  // found, lift_out, drag_out
);
  import iat_pkg::*;

  localparam int IW   = (ANGLE_BINS > 2) ? $clog2(ANGLE_BINS) : 1;
  localparam int DW   = ((IW > 9) ? IW : 9) + 2;
  localparam int FW   = IW + 8;
  localparam int PW   = FW + 34;
  localparam int HALF = ANGLE_BINS / 2;
  localparam int LAST = ANGLE_BINS - 1;

  localparam logic signed [DW-1:0] HALF_S = DW'(HALF);
  localparam logic signed [DW-1:0] BINS_S = DW'(ANGLE_BINS);

  typedef enum logic [2:0] {
    ST_WIPE, ST_IDLE, ST_SCAN, ST_MUL, ST_DIV, ST_WAIT, ST_OUT
  } state_t;

  state_t                state_r;
  logic [IW:0]           addr_r;
  logic signed [15:0]    angle_r;
  logic [64:0]           rd_data_r;
  logic [IW-1:0]         rd_idx_r;
  logic                  rd_live_r;
  logic                  pre_ok_r;
  logic [IW-1:0]         pre_idx_r;
  logic [63:0]           pre_pair_r;
  logic [63:0]           post_pair_r;
  logic [FW-1:0]         d_r;
  logic [FW-1:0]         den_r;
  logic                  sel_r;
  logic signed [PW-1:0]  prod_r;
  logic                  neg_r;
  logic                  res_found_r;
  logic [31:0]           res_lift_r;
  logic [31:0]           res_drag_r;
  logic                  out_tvalid_r;
  logic [OUT_W-1:0]      out_tdata_r;

  logic [64:0]           mem [ANGLE_BINS];

  // Input fields
  logic [1:0]            in_cmd;
  logic signed [15:0]    in_angle;
  logic [31:0]           in_lift;
  logic [31:0]           in_drag;
  logic                  in_fire;

  // Store rounding
  logic [16:0]           st_mag;
  logic [8:0]            st_rnd;
  logic signed [DW-1:0]  st_deg;
  logic signed [DW-1:0]  st_idx;
  logic                  st_ok;

  // Memory port
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [64:0]           mem_wdata;
  logic [IW-1:0]         mem_raddr;

  // Scan compare
  logic signed [DW+7:0]  ang_x;
  logic signed [DW-1:0]  rd_deg;
  logic signed [DW+7:0]  rd_pos;
  logic signed [DW-1:0]  pre_deg;
  logic signed [DW+7:0]  pre_pos;
  logic signed [DW+7:0]  d_full;
  logic [IW-1:0]         span;

  // Interpolation datapath
  logic signed [32:0]    op_a;
  logic signed [32:0]    op_b;
  logic signed [32:0]    op_diff;
  logic [PW-1:0]         prod_mag;
  logic                  div_start;
  logic                  div_done;
  logic [PW-1:0]         div_quo;
  logic signed [32:0]    q_s;
  logic signed [32:0]    lerp;

  assign in_cmd   = in_tdata[1:0];
  assign in_angle = in_tdata[17:2];
  assign in_lift  = in_tdata[49:18];
  assign in_drag  = in_tdata[81:50];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Round the store angle to a whole degree, halves away from zero
  always_comb begin
    st_mag = in_angle[15] ? (17'd0 - {in_angle[15], in_angle}) : {1'b0, in_angle};
    st_rnd = 9'((st_mag + 17'd128) >> 8);
    st_deg = in_angle[15] ? -$signed({{(DW-9){1'b0}}, st_rnd})
                          : $signed({{(DW-9){1'b0}}, st_rnd});
    st_idx = st_deg + HALF_S;
    st_ok  = (st_idx >= 0) && (st_idx < BINS_S);
  end

  // Pick the write port: wipe sweep or store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r[IW-1:0];
    mem_wdata = '0;
    if (state_r == ST_WIPE) begin
      mem_we = 1'b1;
    end else if (in_fire && (in_cmd == CMD_STORE) && st_ok) begin
      mem_we    = 1'b1;
      mem_waddr = st_idx[IW-1:0];
      mem_wdata = {1'b1, in_drag, in_lift};
    end
  end

  assign mem_raddr = addr_r[IW-1:0];

  // Bin memory: valid bit over drag over lift
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Bin positions in Q8.8 for the compare
  always_comb begin
    ang_x   = (DW+8)'(angle_r);
    rd_deg  = $signed({{(DW-IW){1'b0}}, rd_idx_r}) - HALF_S;
    rd_pos  = {rd_deg, 8'd0};
    pre_deg = $signed({{(DW-IW){1'b0}}, pre_idx_r}) - HALF_S;
    pre_pos = {pre_deg, 8'd0};
    d_full  = ang_x - pre_pos;
    span    = rd_idx_r - pre_idx_r;
  end

  // Operands for the lift or the drag pass
  always_comb begin
    op_a     = sel_r ? 33'($signed(pre_pair_r[63:32])) : 33'($signed(pre_pair_r[31:0]));
    op_b     = sel_r ? 33'($signed(post_pair_r[63:32])) : 33'($signed(post_pair_r[31:0]));
    op_diff  = op_b - op_a;
    prod_mag = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
    div_start = (state_r == ST_DIV);
    q_s      = neg_r ? -$signed(div_quo[32:0]) : $signed(div_quo[32:0]);
    lerp     = op_a + q_s;
  end

  iat_div #(
    .NW(PW),
    .VW(FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_mag),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_WIPE;
      addr_r       <= '0;
      rd_live_r    <= 1'b0;
      pre_ok_r     <= 1'b0;
      sel_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_live_r <= (state_r == ST_SCAN) && (addr_r < (IW+1)'(ANGLE_BINS));
      rd_idx_r  <= addr_r[IW-1:0];
      // Load a finished result or drop an accepted one
      if ((state_r == ST_OUT) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_WIPE: begin
          addr_r <= addr_r + (IW+1)'(1);
          if (addr_r[IW-1:0] == IW'(LAST)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            addr_r   <= '0;
            pre_ok_r <= 1'b0;
            angle_r  <= in_angle;
            if (in_cmd == CMD_CLEAR) begin
              state_r <= ST_WIPE;
            end else if (in_cmd == CMD_QUERY) begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (addr_r < (IW+1)'(ANGLE_BINS)) begin
            addr_r <= addr_r + (IW+1)'(1);
          end
          if (rd_live_r && rd_data_r[64] && (rd_pos == ang_x)) begin
            // exact hit
            res_found_r <= 1'b1;
            res_lift_r  <= rd_data_r[31:0];
            res_drag_r  <= rd_data_r[63:32];
            state_r     <= ST_OUT;
          end else if (rd_live_r && rd_data_r[64] && (rd_pos > ang_x)) begin
            // first bin above: interpolate or give up
            if (pre_ok_r) begin
              post_pair_r <= rd_data_r[63:0];
              d_r         <= d_full[FW-1:0];
              den_r       <= {span, 8'd0};
              sel_r       <= 1'b0;
              state_r     <= ST_MUL;
            end else begin
              res_found_r <= 1'b0;
              res_lift_r  <= '0;
              res_drag_r  <= '0;
              state_r     <= ST_OUT;
            end
          end else if (rd_live_r) begin
            if (rd_data_r[64]) begin
              pre_ok_r   <= 1'b1;
              pre_idx_r  <= rd_idx_r;
              pre_pair_r <= rd_data_r[63:0];
            end
            if (rd_idx_r == IW'(LAST)) begin
              res_found_r <= 1'b0;
              res_lift_r  <= '0;
              res_drag_r  <= '0;
              state_r     <= ST_OUT;
            end
          end
        end
        ST_MUL: begin
          prod_r  <= op_diff * $signed({1'b0, d_r});
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          neg_r   <= prod_r[PW-1];
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            if (!sel_r) begin
              res_lift_r <= lerp[31:0];
              sel_r      <= 1'b1;
              state_r    <= ST_MUL;
            end else begin
              res_drag_r  <= lerp[31:0];
              res_found_r <= 1'b1;
              state_r     <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= OUT_W'({res_drag_r, res_lift_r, res_found_r});
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== src/iat_checker.sv =====
module iat_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_tready,
  input logic                    out_tvalid,
  input logic                    out_tready,
  input logic [iat_pkg::OUT_W-1:0] out_tdata
);
  import iat_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A miss carries zero forces
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[OUT_USED-1:1] == '0)
    else $error("miss with nonzero forces");

  // Keep the pad bits clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:OUT_USED] == '0)
    else $error("pad bits set");

  // Drop the result valid and in_tready under reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("channel active after reset");

endmodule

bind interpolating_angle_table_top iat_checker u_iat_checker (.*);

// ===== verif/tb_interpolating_angle_table_top.sv =====
module tb_interpolating_angle_table_top;
  import iat_pkg::*;

  // Unused command code; the block must ignore it
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int BINS = 256;
  localparam int HALF = BINS / 2;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 800;
  localparam int IDLE_PCT = 27;

  typedef struct packed {
    logic               found;
    logic signed [31:0] lift;
    logic signed [31:0] drag;
  } lookup_answer_t;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] angle;
    logic signed [31:0] lift;
    logic signed [31:0] drag;
    bit                 typed;
    lookup_answer_t     answer;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // Predictor's copy of the table
  bit                 bin_filled [BINS];
  logic signed [31:0] bin_lift [BINS];
  logic signed [31:0] bin_drag [BINS];

  lookup_answer_t answers_due[$];
  table_row_t     directed_rows[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 1'b0;

  interpolating_angle_table_top #(.ANGLE_BINS(BINS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cut the run off if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("interpolating_angle_table_top verification failed");
      $finish;
    end
  end

  // Stall the result side at random outside the calm stretch
  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // Interpolate one field between two filled bins, truncating toward zero
  function automatic logic signed [31:0] lerp_field(longint a, longint b, longint d,
                                                    longint den);
    longint r;
    r = a + ((b - a) * d) / den;
    return r[31:0];
  endfunction

  // Apply one item to the table copy; produce the answer a query gives
  task automatic table_apply(input logic [1:0] cmd, input logic signed [15:0] angle,
                             input logic signed [31:0] lift,
                             input logic signed [31:0] drag,
                             output bit answers, output lookup_answer_t ans);
    longint q, deg, idx, pos, pre, post, d, den;
    q = angle;
    answers = 1'b0;
    ans = '0;
    case (cmd)
      CMD_STORE: begin
        deg = (q >= 0) ? (q + 128) / 256 : -((-q + 128) / 256);
        idx = deg + HALF;
        if (idx >= 0 && idx < BINS) begin
          bin_filled[idx] = 1'b1;
          bin_lift[idx] = lift;
          bin_drag[idx] = drag;
        end
      end
      CMD_CLEAR: begin
        foreach (bin_filled[i]) bin_filled[i] = 1'b0;
      end
      CMD_QUERY: begin
        answers = 1'b1;
        pre = -1;
        post = -1;
        for (int i = 0; i < BINS; i++) begin
          if (bin_filled[i]) begin
            pos = (longint'(i) - HALF) * 256;
            if (pos == q) begin
              ans.found = 1'b1;
              ans.lift = bin_lift[i];
              ans.drag = bin_drag[i];
              break;
            end
            if (pos < q) pre = i;
            else if (post < 0) post = i;
          end
        end
        if (!ans.found && pre >= 0 && post >= 0) begin
          d = q - (pre - HALF) * 256;
          den = (post - pre) * 256;
          ans.found = 1'b1;
          ans.lift = lerp_field(bin_lift[pre], bin_lift[post], d, den);
          ans.drag = lerp_field(bin_drag[pre], bin_drag[post], d, den);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item, with random idle cycles ahead of it; record what it should return
  task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] angle,
                           input logic signed [31:0] lift,
                           input logic signed [31:0] drag,
                           input bit typed, input lookup_answer_t typed_ans);
    bit answers;
    lookup_answer_t ans;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, drag, lift, angle, cmd};
    do @(posedge clk); while (!in_tready);
    table_apply(cmd, angle, lift, drag, answers, ans);
    if (answers) answers_due.push_back(typed ? typed_ans : ans);
    @(negedge clk);
  endtask

  task automatic add_row(input logic [1:0] cmd, input int angle, input logic [31:0] lift,
                         input logic [31:0] drag, input int typed = 0,
                         input int found = 0, input logic [31:0] l = '0,
                         input logic [31:0] d = '0);
    table_row_t r;
    r.cmd = cmd;
    r.angle = angle[15:0];
    r.lift = lift;
    r.drag = drag;
    r.typed = typed[0];
    r.answer = '{found[0], l, d};
    directed_rows.push_back(r);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", out_tdata[64:0]);
      end else begin
        lookup_answer_t want;
        want = answers_due.pop_front();
        if (out_tdata[0] !== want.found || out_tdata[32:1] !== want.lift ||
            out_tdata[64:33] !== want.drag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected found=%0d lift=%h drag=%h, got found=%0d lift=%h drag=%h",
                     want.found, want.lift, want.drag,
                     out_tdata[0], out_tdata[32:1], out_tdata[64:33]);
        end
      end
    end
  end

  initial begin
    int r, deg, ang;
    logic [1:0] cmd;
    foreach (bin_filled[i]) bin_filled[i] = 1'b0;

    // Query on an empty table, bins at both ends, exact hits
    add_row(CMD_QUERY, 0, 32'h1234_5678, 32'h9abc_def0, 1, 0, 0, 0);
    add_row(CMD_STORE, -32768, 32'h7fff_ffff, 32'h8000_0000);
    add_row(CMD_STORE, 127 * 256, 32'h8000_0000, 32'h7fff_ffff);
    add_row(CMD_QUERY, -32768, 0, 0, 1, 1, 32'h7fff_ffff, 32'h8000_0000);
    add_row(CMD_QUERY, 127 * 256, 0, 0, 1, 1, 32'h8000_0000, 32'h7fff_ffff);
    add_row(CMD_QUERY, 0, 0, 0);
    // Above the last bin there is no upper neighbour
    add_row(CMD_QUERY, 32767, 0, 0, 1, 0, 0, 0);
    // 127.5 rounds to a degree with no bin: ignored
    add_row(CMD_STORE, 16'h7f80, 1, 1);
    add_row(CMD_QUERY, 127 * 256, 0, 0, 1, 1, 32'h8000_0000, 32'h7fff_ffff);
    // Halves round away from zero
    add_row(CMD_STORE, 16'h0080, 100, -100);
    add_row(CMD_STORE, -128, -5, 5);
    add_row(CMD_STORE, 16'h007f, 7, 9);
    add_row(CMD_QUERY, 0, 0, 0, 1, 1, 7, 9);
    add_row(CMD_QUERY, 16'h0040, 0, 0);
    add_row(CMD_QUERY, -64, 0, 0);
    add_row(CMD_QUERY, 256, 0, 0, 1, 1, 100, -100);
    add_row(CMD_NONE, 256, 32'hffff_ffff, 32'hffff_ffff);
    add_row(CMD_QUERY, -256, 0, 0, 1, 1, -5, 5);
    add_row(CMD_CLEAR, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 1, 0, 0, 0);
    add_row(CMD_STORE, -32768, -1, -1);
    add_row(CMD_QUERY, -32767, 0, 0, 1, 0, 0, 0);
    add_row(CMD_STORE, -32768 + 5 * 256, 32'h4000_0000, -7);
    add_row(CMD_QUERY, -32768 + 384, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].angle, directed_rows[i].lift,
                directed_rows[i].drag, directed_rows[i].typed, directed_rows[i].answer);

    // Mostly stores near whole degrees and queries, some clears and junk
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 300 && n < 450);
      r = $urandom_range(99);
      deg = $urandom_range(255) - HALF;
      if (r < 3) cmd = CMD_CLEAR;
      else if (r < 6) cmd = CMD_NONE;
      else if (r < 52) cmd = CMD_STORE;
      else cmd = CMD_QUERY;
      case ($urandom_range(2))
        0: ang = $urandom;
        1: ang = deg * 256;
        default: ang = deg * 256 + $urandom_range(255) - 128;
      endcase
      send_item(cmd, ang[15:0], $urandom, $urandom, 1'b0, '0);
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && answers_due.size() == 0)
      $display("interpolating_angle_table_top verification clean");
    else
      $display("interpolating_angle_table_top verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/iat_pkg.sv
src/iat_div.sv
src/interpolating_angle_table_top.sv
src/iat_checker.sv
verif/tb_interpolating_angle_table_top.sv
